// ----- sv/assert_macros.svh -----
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define CRCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define CRCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/crcfr_pkg.sv -----
// Shared types, constants and the CRC step function of the deframer.
package crcfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int LEN_W           = 7;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0]  SYNC1_BYTE = 8'hC3;
  localparam logic [7:0]  SYNC2_BYTE = 8'h33;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  localparam logic [5:0]  MAX_PAYLOAD_RST = 6'd32;
  localparam logic [15:0] CRC_START_RST   = 16'hFFFF;

  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_CRC_START   = 1'b1;

  typedef struct packed {
    logic [7:0]       frame_type;
    logic [LEN_W-1:0] frame_length;
    logic             bank;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((a & CRC_TOP) != 16'h0000) begin
        a = {a[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        a = {a[14:0], 1'b0};
      end
    end
    return a;
  endfunction

endpackage

// ----- sv/crcfr_buf.sv -----
// Two-bank payload buffer: one write port, one registered read port.
module crcfr_buf #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [2**AW];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/crcfr_fifo.sv -----
// Two-entry descriptor queue between the parser and the emitter.
`include "assert_macros.svh"

module crcfr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crcfr_pkg::desc_t     push_data,
  input  logic                 pop,
  output logic                 head_valid,
  output crcfr_pkg::desc_t     head_data,
  output logic                 full
);

  crcfr_pkg::desc_t entry_r [crcfr_pkg::QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] count_nxt;

  assign head_valid = (count_r != 2'd0);
  assign head_data  = entry_r[rd_ptr_r];
  assign full       = (count_r == 2'(crcfr_pkg::QUEUE_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `CRCFR_ASSERT(a_no_overflow, !(push && full && !pop), "descriptor queue overflow")
  `CRCFR_ASSERT(a_no_underflow, !(pop && !head_valid), "descriptor queue underflow")

endmodule

// ----- sv/crcfr_front.sv -----
// Byte parser: sync hunt, header, CRC check, payload write, descriptor push.
`include "assert_macros.svh"

module crcfr_front #(
  parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF,
  parameter int IW          = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  wr_en,
  output logic [IW:0]           wr_addr,
  output logic [7:0]            wr_data,
  output logic                  push,
  output crcfr_pkg::desc_t      push_data,
  input  crcfr_pkg::rel_t       rel
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI, PH_SKIP_PAY, PH_SKIP_CRC
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        sync_ok_r, sync_ok_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic        bank_r, bank_nxt;
  logic [1:0]  busy_r, busy_nxt;
  logic [5:0]  max_payload_r, max_payload_nxt;
  logic [15:0] crc_start_r, crc_start_nxt;

  logic        xfer;
  logic [15:0] limit;
  logic [15:0] len_full;
  logic [15:0] crc_in;
  logic [15:0] crc_step;

  assign in_ready = !(((phase_r == PH_PAYLOAD) || (phase_r == PH_CRC_HI)) && busy_r[bank_r]);
  assign xfer     = in_valid && in_ready;
  assign limit    = ({10'd0, max_payload_r} < 16'(MAX_PAYLOAD)) ? {10'd0, max_payload_r}
                                                               : 16'(MAX_PAYLOAD);
  assign len_full = {in_rx_byte, len_r[7:0]};
  assign crc_in   = (phase_r == PH_HEADER && cnt_r == 16'd2) ? crc_start_r : crc_r;
  assign crc_step = crcfr_pkg::crc_feed(crc_in, in_rx_byte);

  assign wr_en   = xfer && (phase_r == PH_PAYLOAD) && (cnt_r < 16'(MAX_PAYLOAD));
  assign wr_addr = {bank_r, cnt_r[IW-1:0]};
  assign wr_data = in_rx_byte;

  assign push_data.frame_type   = kind_r;
  assign push_data.frame_length = len_r[crcfr_pkg::LEN_W-1:0];
  assign push_data.bank         = bank_r;

  always_comb begin
    phase_nxt       = phase_r;
    cnt_nxt         = cnt_r;
    sync_ok_nxt     = sync_ok_r;
    kind_nxt        = kind_r;
    len_nxt         = len_r;
    crc_nxt         = crc_r;
    crc_lo_nxt      = crc_lo_r;
    bank_nxt        = bank_r;
    busy_nxt        = busy_r;
    max_payload_nxt = max_payload_r;
    crc_start_nxt   = crc_start_r;
    push            = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        crcfr_pkg::REG_MAX_PAYLOAD: max_payload_nxt = cfg_wdata[5:0];
        crcfr_pkg::REG_CRC_START:   crc_start_nxt   = cfg_wdata;
        default: ;
      endcase
    end

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    if (xfer) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == crcfr_pkg::SYNC1_BYTE) begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = 16'd1;
          end
        end
        PH_HEADER: begin
          cnt_nxt = cnt_r + 16'd1;
          case (cnt_r)
            16'd1: sync_ok_nxt = (in_rx_byte == crcfr_pkg::SYNC2_BYTE);
            16'd2: begin
              kind_nxt = in_rx_byte;
              crc_nxt  = crc_step;
            end
            16'd3: begin
              len_nxt = {8'd0, in_rx_byte};
              crc_nxt = crc_step;
            end
            default: begin
              len_nxt = len_full;
              crc_nxt = crc_step;
              cnt_nxt = 16'd0;
              if (!sync_ok_r) begin
                phase_nxt = PH_HUNT;
              end else if (len_full > limit) begin
                phase_nxt = PH_SKIP_PAY;
                cnt_nxt   = len_full;
              end else if (len_full == 16'd0) begin
                phase_nxt = PH_CRC_LO;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          crc_nxt = crc_step;
          cnt_nxt = cnt_r + 16'd1;
          if (cnt_nxt >= len_r) begin
            phase_nxt = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_lo_nxt = in_rx_byte;
          phase_nxt  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = 16'd0;
          if ({in_rx_byte, crc_lo_r} == crc_r) begin
            push             = 1'b1;
            busy_nxt[bank_r] = 1'b1;
            bank_nxt         = ~bank_r;
          end
        end
        PH_SKIP_PAY: begin
          cnt_nxt = cnt_r - 16'd1;
          if (cnt_r == 16'd1) begin
            phase_nxt = PH_SKIP_CRC;
            cnt_nxt   = 16'd2;
          end
        end
        PH_SKIP_CRC: begin
          cnt_nxt = cnt_r - 16'd1;
          if (cnt_r == 16'd1) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = 16'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      cnt_r         <= 16'd0;
      sync_ok_r     <= 1'b0;
      kind_r        <= 8'd0;
      len_r         <= 16'd0;
      crc_r         <= crcfr_pkg::CRC_START_RST;
      crc_lo_r      <= 8'd0;
      bank_r        <= 1'b0;
      busy_r        <= 2'b00;
      max_payload_r <= crcfr_pkg::MAX_PAYLOAD_RST;
      crc_start_r   <= crcfr_pkg::CRC_START_RST;
    end else begin
      phase_r       <= phase_nxt;
      cnt_r         <= cnt_nxt;
      sync_ok_r     <= sync_ok_nxt;
      kind_r        <= kind_nxt;
      len_r         <= len_nxt;
      crc_r         <= crc_nxt;
      crc_lo_r      <= crc_lo_nxt;
      bank_r        <= bank_nxt;
      busy_r        <= busy_nxt;
      max_payload_r <= max_payload_nxt;
      crc_start_r   <= crc_start_nxt;
    end
  end

  `CRCFR_ASSERT(a_push_free_bank, !(push && busy_r[bank_r]), "frame pushed into busy bank")
  `CRCFR_ASSERT(a_release_busy, !rel.valid || busy_r[rel.bank], "release of idle bank")

endmodule

// ----- sv/crcfr_back.sv -----
// Result emitter: walks each queued frame and streams its payload bytes.
`include "assert_macros.svh"

module crcfr_back #(
  parameter int IW = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  crcfr_pkg::desc_t      head_data,
  output logic                  pop,
  output crcfr_pkg::rel_t       rel,
  output logic                  rd_en,
  output logic [IW:0]           rd_addr,
  input  logic [7:0]            rd_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_frame_type,
  output logic [7:0]            out_payload_byte,
  output logic [4:0]            out_byte_index,
  output logic [5:0]            out_frame_length,
  output logic                  out_last
);

  logic [crcfr_pkg::LEN_W-1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] type_r;
  logic [4:0] index_r;
  logic [5:0] length_r;
  logic       last_r;
  logic       empty_r;

  logic load;
  logic last_cur;
  logic empty_cur;

  assign empty_cur = (head_data.frame_length == '0);
  assign last_cur  = empty_cur ||
                     (crcfr_pkg::LEN_W'(idx_r + 1'b1) == head_data.frame_length);
  assign load      = head_valid && (!out_valid_r || out_ready);
  assign pop       = load && last_cur;
  assign rel.valid = pop;
  assign rel.bank  = head_data.bank;
  assign rd_en     = load;
  assign rd_addr   = {head_data.bank, idx_r[IW-1:0]};

  always_comb begin
    idx_nxt = idx_r;
    if (pop) begin
      idx_nxt = '0;
    end else if (load) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      type_r   <= head_data.frame_type;
      index_r  <= idx_r[4:0];
      length_r <= head_data.frame_length[5:0];
      last_r   <= last_cur;
      empty_r  <= empty_cur;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_type   = type_r;
  assign out_payload_byte = empty_r ? 8'd0 : rd_data;
  assign out_byte_index   = index_r;
  assign out_frame_length = length_r;
  assign out_last         = last_r;

  `CRCFR_ASSERT(a_idx_in_frame,
    !head_valid || empty_cur || (idx_r < head_data.frame_length),
    "emit index past frame length")

endmodule

// ----- sv/crc16_frame_receiver_core.sv -----
// Top level of the CRC-16 packet deframer: parser, queue, payload buffer, emitter.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_rx_byte
//   out_     output     out_valid / out_ready   type, byte, index, length, last
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// One received byte is taken per cycle; the parser holds in_ready low only while the
// payload bank it must write still holds a frame that is waiting to be emitted.
// Payload banks are double buffered, so one frame can drain while the next is parsed.
// Emitter: one result per cycle when out_ready allows, via the registered buffer port.
// Reset is synchronous; no clearing pass, the block is ready the cycle after reset.
`include "assert_macros.svh"

module crc16_frame_receiver_core #(
  parameter int MAX_PAYLOAD = crcfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_type,
  output logic [7:0]  out_payload_byte,
  output logic [4:0]  out_byte_index,
  output logic [5:0]  out_frame_length,
  output logic        out_last
);

  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic             wr_en;
  logic [IW:0]      wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [IW:0]      rd_addr;
  logic [7:0]       rd_data;
  logic             push;
  crcfr_pkg::desc_t push_data;
  logic             pop;
  logic             head_valid;
  crcfr_pkg::desc_t head_data;
  logic             q_full;
  crcfr_pkg::rel_t  rel;

  crcfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .IW          (IW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .push       (push),
    .push_data  (push_data),
    .rel        (rel)
  );

  crcfr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (q_full)
  );

  crcfr_buf #(
    .AW (IW + 1)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crcfr_back #(
    .IW (IW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_data        (head_data),
    .pop              (pop),
    .rel              (rel),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_type   (out_frame_type),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  `CRCFR_ASSERT(a_push_room, !(push && q_full), "frame accepted with full descriptor queue")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the CRC-16 frame receiver core.
module tb_top;

  localparam int CLK_HALF     = 4;
  localparam int RST_CYCLES   = 4;
  localparam int DRAIN_PAD    = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 10;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PRINT_CAP    = 100;

  typedef enum logic [2:0] {
    PS_HUNT, PS_HEADER, PS_PAYLOAD, PS_CRC_LO, PS_CRC_HI, PS_SKIP_PAY, PS_SKIP_CRC
  } parse_e;

  typedef enum logic [2:0] {FR_GOOD, FR_BAD_CRC, FR_BAD_SYNC, FR_LONG, FR_CUT} frame_e;
  typedef enum logic {ROW_FRAME, ROW_REG} row_e;

  typedef struct packed {
    logic [7:0] ftype;
    logic [7:0] data;
    logic [4:0] idx;
    logic [5:0] flen;
    logic       is_last;
  } run_beat_t;

  typedef struct {
    row_e        op;
    frame_e      fk;
    logic [7:0]  ftype;
    logic [15:0] flen;
    logic        reg_idx;
    logic [15:0] reg_val;
    int          exp_n;
  } dir_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_we      = 1'b0;
  logic        cfg_index   = 1'b0;
  logic [15:0] cfg_wdata   = 16'h0000;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte  = 8'h00;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [7:0]  out_frame_type;
  logic [7:0]  out_payload_byte;
  logic [4:0]  out_byte_index;
  logic [5:0]  out_frame_length;
  logic        out_last;

  logic        hold_req    = 1'b0;

  crc16_frame_receiver_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_type   (out_frame_type),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

  // deframer state mirror
  parse_e      ph;
  logic [15:0] cnt;
  logic        sync_ok;
  logic [7:0]  kind_q;
  logic [15:0] len_q;
  logic [15:0] crc_q;
  logic [7:0]  crc_lo_q;
  logic [7:0]  pay_mem [crcfr_pkg::MAX_PAYLOAD_DEF];
  logic [5:0]  cfg_max;
  logic [15:0] cfg_crc;

  run_beat_t   run_q [$];
  run_beat_t   last_pred;
  int          n_predicted = 0;
  int          n_sent      = 0;
  int          err_count   = 0;
  int          burst_left  = 0;
  bit          quiet       = 1'b0;

  dir_row_t dir_rows [7] = '{
    '{ROW_FRAME, FR_GOOD,     8'h00, 16'h0000, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000, 1},
    '{ROW_FRAME, FR_BAD_SYNC, 8'hC3, 16'h3333, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000, 0},
    '{ROW_FRAME, FR_GOOD,     8'hFF, 16'h0001, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000, 1},
    '{ROW_FRAME, FR_BAD_CRC,  8'h5A, 16'h0000, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000, 0},
    '{ROW_REG,   FR_GOOD,     8'h00, 16'h0000, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000, -1},
    '{ROW_FRAME, FR_LONG,     8'h11, 16'h0001, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0000, 0},
    '{ROW_REG,   FR_GOOD,     8'h00, 16'h0000, crcfr_pkg::REG_MAX_PAYLOAD, 16'h0020, -1}
  };

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= PRINT_CAP) $display("ERROR %0t: %s", $time, what);
  endtask

  function automatic logic [15:0] crc_advance(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] a;
    logic        fb;
    a = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = a[15] ^ b[k];
      a = {a[14:0], 1'b0};
      if (fb) a = a ^ crcfr_pkg::CRC_POLY;
    end
    return a;
  endfunction

  function automatic int eff_limit();
    return (cfg_max < crcfr_pkg::MAX_PAYLOAD_DEF) ? int'(cfg_max)
                                                  : crcfr_pkg::MAX_PAYLOAD_DEF;
  endfunction

  task automatic clear_model();
    ph       = PS_HUNT;
    cnt      = 16'd0;
    sync_ok  = 1'b0;
    kind_q   = 8'h00;
    len_q    = 16'd0;
    crc_q    = crcfr_pkg::CRC_START_RST;
    crc_lo_q = 8'h00;
    cfg_max  = crcfr_pkg::MAX_PAYLOAD_RST;
    cfg_crc  = crcfr_pkg::CRC_START_RST;
    foreach (pay_mem[k]) pay_mem[k] = 8'h00;
  endtask

  task automatic push_beat(input run_beat_t beat);
    run_q.push_back(beat);
    last_pred = beat;
    n_predicted++;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int lim;
    run_beat_t beat;
    case (ph)
      PS_HUNT: begin
        if (b == crcfr_pkg::SYNC1_BYTE) begin
          ph  = PS_HEADER;
          cnt = 16'd1;
        end
      end
      PS_HEADER: begin
        case (cnt)
          16'd1: sync_ok = (b == crcfr_pkg::SYNC2_BYTE);
          16'd2: begin
            kind_q = b;
            crc_q  = crc_advance(cfg_crc, b);
          end
          16'd3: begin
            len_q = {8'h00, b};
            crc_q = crc_advance(crc_q, b);
          end
          default: begin
            len_q = {b, len_q[7:0]};
            crc_q = crc_advance(crc_q, b);
          end
        endcase
        cnt = cnt + 16'd1;
        if (cnt >= 16'd5) begin
          lim = eff_limit();
          cnt = 16'd0;
          if (!sync_ok) begin
            ph = PS_HUNT;
          end else if (int'(len_q) > lim) begin
            ph  = PS_SKIP_PAY;
            cnt = len_q;
          end else if (len_q == 16'd0) begin
            ph = PS_CRC_LO;
          end else begin
            ph = PS_PAYLOAD;
          end
        end
      end
      PS_PAYLOAD: begin
        if (cnt < crcfr_pkg::MAX_PAYLOAD_DEF) pay_mem[cnt[4:0]] = b;
        crc_q = crc_advance(crc_q, b);
        cnt = cnt + 16'd1;
        if (cnt >= len_q) ph = PS_CRC_LO;
      end
      PS_CRC_LO: begin
        crc_lo_q = b;
        ph = PS_CRC_HI;
      end
      PS_CRC_HI: begin
        ph  = PS_HUNT;
        cnt = 16'd0;
        if ({b, crc_lo_q} == crc_q) begin
          if (len_q == 16'd0) begin
            beat = '{kind_q, 8'h00, 5'd0, 6'd0, 1'b1};
            push_beat(beat);
          end else begin
            for (int i = 0; i < int'(len_q) && i < crcfr_pkg::MAX_PAYLOAD_DEF; i++) begin
              beat = '{kind_q, pay_mem[i], 5'(i), len_q[5:0], (i + 1 == int'(len_q))};
              push_beat(beat);
            end
          end
        end
      end
      PS_SKIP_PAY: begin
        cnt = cnt - 16'd1;
        if (cnt == 16'd0) begin
          ph  = PS_SKIP_CRC;
          cnt = 16'd2;
        end
      end
      PS_SKIP_CRC: begin
        cnt = cnt - 16'd1;
        if (cnt == 16'd0) ph = PS_HUNT;
      end
      default: begin
        ph  = PS_HUNT;
        cnt = 16'd0;
      end
    endcase
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = quiet ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
    n_sent++;
    pace();
  endtask

  task automatic send_frame(input frame_e fk, input logic [7:0] ftype, input logic [15:0] flen);
    logic [15:0] crc;
    logic [7:0]  sync2;
    logic [7:0]  pb;
    int          n_pay;
    crc = crc_advance(cfg_crc, ftype);
    crc = crc_advance(crc, flen[7:0]);
    crc = crc_advance(crc, flen[15:8]);
    sync2 = crcfr_pkg::SYNC2_BYTE;
    if (fk == FR_BAD_SYNC) begin
      while (sync2 == crcfr_pkg::SYNC2_BYTE) sync2 = 8'($urandom_range(0, 255));
    end
    send_byte(crcfr_pkg::SYNC1_BYTE);
    send_byte(sync2);
    send_byte(ftype);
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    if (fk == FR_BAD_SYNC) return;
    n_pay = (fk == FR_CUT) ? int'(flen) / 2 : int'(flen);
    for (int i = 0; i < n_pay; i++) begin
      pb  = 8'($urandom_range(0, 255));
      crc = crc_advance(crc, pb);
      send_byte(pb);
    end
    if (fk == FR_CUT) return;
    if (fk == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    if (fk == FR_LONG) crc = 16'($urandom_range(0, 65535));
    send_byte(crc[7:0]);
    send_byte(crc[15:8]);
  endtask

  task automatic send_random_frame();
    int         pick;
    int         lim;
    int         flen;
    int         k;
    logic [7:0] ft;
    pick = $urandom_range(0, 99);
    lim  = eff_limit();
    ft   = 8'($urandom_range(0, 255));
    flen = ($urandom_range(0, 7) == 0) ? lim : $urandom_range(0, (lim < 6) ? lim : 6);
    if (pick < 68) begin
      send_frame(FR_GOOD, ft, 16'(flen));
    end else if (pick < 78) begin
      send_frame(FR_BAD_CRC, ft, 16'(flen));
    end else if (pick < 84) begin
      send_frame(FR_BAD_SYNC, ft, 16'(flen));
    end else if (pick < 90) begin
      send_frame(FR_LONG, ft, 16'(lim + $urandom_range(1, 3)));
    end else if (pick < 94) begin
      send_frame(FR_CUT, ft, 16'(flen));
    end else begin
      k = $urandom_range(1, 4);
      repeat (k) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (run_q.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic program_reg(input logic idx, input logic [15:0] val);
    while (ph != PS_HUNT) send_byte(8'h00);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == crcfr_pkg::REG_MAX_PAYLOAD) cfg_max = val[5:0];
    else cfg_crc = val;
  endtask

  // result sink: stall patterns and one long hold-off on request
  initial begin
    int sink_mode;
    int cyc;
    sink_mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        if (cyc % 96 == 0) sink_mode = $urandom_range(0, 3);
        case (sink_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 9) != 0);
          default: out_ready <= (cyc % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    run_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (run_q.size() == 0) begin
        flag_error("result transfer with nothing expected");
      end else begin
        want = run_q.pop_front();
        if (out_frame_type !== want.ftype)
          flag_error($sformatf("frame_type %02h, want %02h", out_frame_type, want.ftype));
        if (out_payload_byte !== want.data)
          flag_error($sformatf("payload_byte %02h, want %02h", out_payload_byte, want.data));
        if (out_byte_index !== want.idx)
          flag_error($sformatf("byte_index %0d, want %0d", out_byte_index, want.idx));
        if (out_frame_length !== want.flen)
          flag_error($sformatf("frame_length %0d, want %0d", out_frame_length, want.flen));
        if (out_last !== want.is_last)
          flag_error($sformatf("last %b, want %b", out_last, want.is_last));
      end
    end
  end

  initial begin
    int          base_n;
    int          phase_start;
    logic [15:0] mx;
    logic [15:0] cs;
    clear_model();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].op == ROW_REG) begin
        program_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        base_n = n_predicted;
        send_frame(dir_rows[r].fk, dir_rows[r].ftype, dir_rows[r].flen);
        if (dir_rows[r].exp_n >= 0 && n_predicted - base_n != dir_rows[r].exp_n)
          flag_error($sformatf("row %0d gave %0d results, want %0d",
                               r, n_predicted - base_n, dir_rows[r].exp_n));
        if (dir_rows[r].exp_n == 1 && dir_rows[r].flen == 16'd0 &&
            last_pred !== run_beat_t'{dir_rows[r].ftype, 8'h00, 5'd0, 6'd0, 1'b1})
          flag_error($sformatf("row %0d empty frame result mismatch", r));
      end
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin mx = 16'd32; cs = 16'hFFFF; end
        1: begin mx = 16'd0; cs = 16'h0000; end
        2: begin
          mx = {10'($urandom_range(0, 1023)), 6'd63};
          cs = 16'($urandom_range(0, 65535));
        end
        3: begin mx = 16'd1; cs = 16'hFFFF; end
        4: begin mx = 16'($urandom_range(2, 31)); cs = 16'($urandom_range(0, 65535)); end
        5: begin mx = 16'd32; cs = 16'($urandom_range(0, 65535)); end
        default: begin mx = 16'($urandom_range(0, 32)); cs = 16'h0000; end
      endcase
      program_reg(crcfr_pkg::REG_MAX_PAYLOAD, mx);
      program_reg(crcfr_pkg::REG_CRC_START, cs);
      quiet = (p == 2 || p == 5);
      if (p == 5) begin
        // fill both payload banks while the sink holds off
        hold_req <= 1'b1;
        repeat (3) send_frame(FR_GOOD, 8'($urandom_range(0, 255)), 16'd8);
      end
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS) send_random_frame();
      if (p == 4) send_frame(FR_LONG, 8'($urandom_range(0, 255)), {8'h01, 8'h00});
    end

    wait_drained();
    if (run_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", run_q.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
